// ----- hw/rtl/plet_pkg.sv -----
// shared types and constants for the pinned lru entry table
// depends on nothing; used by the controller, datapath and top level
package plet_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int LIMIT_W      = 5;
    localparam int COUNT_W      = 16;
    localparam int STAMP_W      = 32;
    localparam int SLOT_W       = 4;
    localparam int KIND_W       = 3;
    localparam int KEY_W        = 32;

    localparam logic [KIND_W-1:0] KIND_EVICT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HIT      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REL_ERR  = 3'd5;

    localparam logic REQ_LOAD = 1'b0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic scan_clear;   // restart scan state
        logic scan_step;    // examine the entry under the scan index
        logic do_hit;       // pin the matched entry
        logic do_evict;     // drop the oldest unpinned entry
        logic do_insert;    // write the key to the free slot
        logic do_release;   // unpin the requested slot
        logic [KIND_W-1:0] kind;
        logic last;
        logic load_out;     // capture a result word
    } plet_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic hit_found;
        logic victim_found;
        logic free_found;
        logic evict_needed;
        logic rel_ok;
    } plet_stat_t;

endpackage

// ----- hw/rtl/plet_ctrl.sv -----
// controller state machine for the pinned lru entry table
// depends on plet_pkg; drives the datapath through command and status structs
module plet_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                req_type,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  plet_pkg::plet_stat_t stat,
    output plet_pkg::plet_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_EVSCAN, ST_EVICT, ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   more_reg, more_next;   // further results follow the shown word
    logic   load_reg, load_next;   // current item is a load

    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;

    // sequencing of scans, evictions and result words
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        more_next   = more_reg;
        load_next   = load_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    load_next = (req_type == plet_pkg::REQ_LOAD);
                    cmd.scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!load_reg) begin
                    cmd.do_release = stat.rel_ok;
                    cmd.kind = stat.rel_ok ? plet_pkg::KIND_RELEASED
                                           : plet_pkg::KIND_REL_ERR;
                    cmd.last = 1'b1;
                    cmd.load_out = 1'b1;
                    mvalid_next = 1'b1;
                    more_next = 1'b0;
                    state_next = ST_WAIT;
                end else if (stat.hit_found) begin
                    cmd.do_hit = 1'b1;
                    cmd.kind = plet_pkg::KIND_HIT;
                    cmd.last = 1'b1;
                    cmd.load_out = 1'b1;
                    mvalid_next = 1'b1;
                    more_next = 1'b0;
                    state_next = ST_WAIT;
                end else if (stat.evict_needed && stat.victim_found) begin
                    cmd.do_evict = 1'b1;
                    cmd.kind = plet_pkg::KIND_EVICT;
                    cmd.load_out = 1'b1;
                    mvalid_next = 1'b1;
                    more_next = 1'b1;
                    state_next = ST_WAIT;
                end else begin
                    cmd.do_insert = stat.free_found;
                    cmd.kind = stat.free_found ? plet_pkg::KIND_INSERT
                                               : plet_pkg::KIND_FULL;
                    cmd.last = 1'b1;
                    cmd.load_out = 1'b1;
                    mvalid_next = 1'b1;
                    more_next = 1'b0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!mvalid_reg || m_tready) begin
                    if (more_reg) begin
                        cmd.scan_clear = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            more_reg   <= 1'b0;
            load_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            more_reg   <= more_next;
            load_reg   <= load_next;
        end
    end

endmodule

// ----- hw/rtl/plet_dpath.sv -----
// datapath of the pinned lru entry table: entry store, scan unit, result word
// depends on plet_pkg; commanded by plet_ctrl
module plet_dpath #(
    parameter int CAPACITY = plet_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = plet_pkg::KEY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [plet_pkg::KEY_W-1:0]    in_key,
    input  logic [plet_pkg::SLOT_W-1:0]   in_slot,
    input  logic                          cfg_we,
    input  logic [plet_pkg::LIMIT_W-1:0]  cfg_limit,
    output logic [plet_pkg::LIMIT_W-1:0]  limit_q,
    input  plet_pkg::plet_cmd_t            cmd,
    output plet_pkg::plet_stat_t           stat,
    output logic [plet_pkg::KIND_W-1:0]   out_kind,
    output logic [plet_pkg::SLOT_W-1:0]   out_slot,
    output logic [plet_pkg::KEY_W-1:0]    out_key,
    output logic [plet_pkg::COUNT_W-1:0]  out_count,
    output logic                          out_last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int KB    = (KEY_BITS < plet_pkg::KEY_W) ? KEY_BITS : plet_pkg::KEY_W;

    // entry store, one register row per slot
    logic [CAPACITY-1:0]              valid_reg;
    logic [KB-1:0]                    ekey_reg   [CAPACITY];
    logic [plet_pkg::COUNT_W-1:0]     ecount_reg [CAPACITY];
    logic [plet_pkg::STAMP_W-1:0]     estamp_reg [CAPACITY];
    logic [plet_pkg::STAMP_W-1:0]     stamp_reg;
    logic [OCC_W-1:0]                 occ_reg;
    logic [plet_pkg::LIMIT_W-1:0]     limit_reg;
    logic [plet_pkg::LIMIT_W-1:0]     todo_reg;

    // request and scan registers
    logic [KB-1:0]                    key_reg;
    logic [plet_pkg::SLOT_W-1:0]      rslot_reg;
    logic [IDX_W:0]                   idx_reg;
    logic                             hit_reg, vic_reg, free_reg;
    logic [IDX_W-1:0]                 hit_i_reg, vic_i_reg, free_i_reg;
    logic [plet_pkg::STAMP_W-1:0]     vstamp_reg;

    // result word
    logic [plet_pkg::KIND_W-1:0]      okind_reg;
    logic [plet_pkg::SLOT_W-1:0]      oslot_reg;
    logic [plet_pkg::KEY_W-1:0]       okey_reg;
    logic [plet_pkg::COUNT_W-1:0]     ocount_reg;
    logic                             olast_reg;

    logic [IDX_W-1:0] ci;
    logic             rel_in_range;
    logic [IDX_W-1:0] ri;
    logic [plet_pkg::COUNT_W-1:0] hit_cnt;
    logic [plet_pkg::LIMIT_W:0]   need;

    assign ci = idx_reg[IDX_W-1:0];
    assign rel_in_range = ({{(32-plet_pkg::SLOT_W){1'b0}}, rslot_reg} < 32'(CAPACITY));
    assign ri = IDX_W'(rslot_reg);
    assign hit_cnt = (ecount_reg[hit_i_reg] == plet_pkg::COUNT_MAX)
                   ? plet_pkg::COUNT_MAX : ecount_reg[hit_i_reg] + 1'b1;
    assign need = {1'b0, plet_pkg::LIMIT_W'(occ_reg)} + 1'b1
                - {1'b0, limit_reg};

    // status to the controller
    always_comb begin
        stat.scan_done    = (idx_reg == (IDX_W+1)'(CAPACITY - 1)) || idx_reg[IDX_W];
        stat.hit_found    = hit_reg;
        stat.victim_found = vic_reg;
        stat.free_found   = free_reg;
        stat.evict_needed = (todo_reg != '0);
        stat.rel_ok       = rel_in_range && valid_reg[ri] && (ecount_reg[ri] != '0);
    end

    assign limit_q   = limit_reg;
    assign out_kind  = okind_reg;
    assign out_slot  = oslot_reg;
    assign out_key   = okey_reg;
    assign out_count = ocount_reg;
    assign out_last  = olast_reg;

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            stamp_reg <= '0;
            occ_reg   <= '0;
            limit_reg <= plet_pkg::LIMIT_W'(16);
            todo_reg  <= '0;
        end else begin
            if (cfg_we) limit_reg <= cfg_limit;
            // eviction budget is set once per accepted request, at acceptance
            if (accept)
                todo_reg <= ({1'b0, plet_pkg::LIMIT_W'(occ_reg)} >= {1'b0, limit_reg})
                          ? need[plet_pkg::LIMIT_W-1:0] : '0;
            if (cmd.do_evict) begin
                valid_reg[vic_i_reg] <= 1'b0;
                occ_reg  <= occ_reg - 1'b1;
                todo_reg <= todo_reg - 1'b1;
            end
            if (cmd.do_insert) begin
                valid_reg[free_i_reg] <= 1'b1;
                occ_reg   <= occ_reg + 1'b1;
                stamp_reg <= stamp_reg + 1'b1;
            end
            if (cmd.do_hit) stamp_reg <= stamp_reg + 1'b1;
        end
    end

    // scan over the entries, one per cycle, and entry updates
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg   <= in_key[KB-1:0];
            rslot_reg <= in_slot;
        end
        if (cmd.scan_clear) begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            vic_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + 1'b1;
            if (valid_reg[ci] && ekey_reg[ci] == key_reg && !hit_reg) begin
                hit_reg   <= 1'b1;
                hit_i_reg <= ci;
            end
            if (valid_reg[ci] && ecount_reg[ci] == '0
                && (!vic_reg || estamp_reg[ci] < vstamp_reg)) begin
                vic_reg    <= 1'b1;
                vic_i_reg  <= ci;
                vstamp_reg <= estamp_reg[ci];
            end
            if (!valid_reg[ci] && !free_reg) begin
                free_reg   <= 1'b1;
                free_i_reg <= ci;
            end
        end
        if (cmd.do_hit) begin
            ecount_reg[hit_i_reg] <= hit_cnt;
            estamp_reg[hit_i_reg] <= stamp_reg;
        end
        if (cmd.do_insert) begin
            ekey_reg[free_i_reg]   <= key_reg;
            ecount_reg[free_i_reg] <= plet_pkg::COUNT_W'(1);
            estamp_reg[free_i_reg] <= stamp_reg;
        end
        if (cmd.do_release)
            ecount_reg[ri] <= ecount_reg[ri] - 1'b1;
    end

    // result word capture
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            okind_reg <= cmd.kind;
            olast_reg <= cmd.last;
            case (cmd.kind)
                plet_pkg::KIND_HIT: begin
                    oslot_reg  <= plet_pkg::SLOT_W'(hit_i_reg);
                    okey_reg   <= plet_pkg::KEY_W'(key_reg);
                    ocount_reg <= hit_cnt;
                end
                plet_pkg::KIND_EVICT: begin
                    oslot_reg  <= plet_pkg::SLOT_W'(vic_i_reg);
                    okey_reg   <= plet_pkg::KEY_W'(ekey_reg[vic_i_reg]);
                    ocount_reg <= '0;
                end
                plet_pkg::KIND_INSERT: begin
                    oslot_reg  <= plet_pkg::SLOT_W'(free_i_reg);
                    okey_reg   <= plet_pkg::KEY_W'(key_reg);
                    ocount_reg <= plet_pkg::COUNT_W'(1);
                end
                plet_pkg::KIND_FULL: begin
                    oslot_reg  <= '0;
                    okey_reg   <= plet_pkg::KEY_W'(key_reg);
                    ocount_reg <= '0;
                end
                plet_pkg::KIND_RELEASED: begin
                    oslot_reg  <= rslot_reg;
                    okey_reg   <= plet_pkg::KEY_W'(ekey_reg[ri]);
                    ocount_reg <= ecount_reg[ri] - 1'b1;
                end
                default: begin
                    oslot_reg  <= rslot_reg;
                    okey_reg   <= (rel_in_range && valid_reg[ri])
                                ? plet_pkg::KEY_W'(ekey_reg[ri]) : '0;
                    ocount_reg <= '0;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/pinned_lru_entry_table.sv -----
// top level of the pinned lru entry table: stream ports and apb register
// depends on plet_pkg, plet_ctrl and plet_dpath
//
// A keyed table of CAPACITY entries with pin counts and least-recently-used
// eviction of unpinned entries. One request is handled at a time. A scan
// visits one entry per cycle, and a hit, insert or table-full result is
// given once the scan that follows acceptance of the word is through; each
// eviction costs one further scan, started on consumption of the eviction
// word, before the next result. A release also passes one scan. The next word
// is taken once the last result has been consumed. Register entry_limit lies
// at address 0.
module pinned_lru_entry_table #(
    parameter int CAPACITY = plet_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = plet_pkg::KEY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[31:0], slot[35:32], zero fill
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // slot_res[3:0], key_res[35:4], use_count[51:36]
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    plet_pkg::plet_cmd_t  cmd;
    plet_pkg::plet_stat_t stat;
    logic [plet_pkg::LIMIT_W-1:0]  limit_q;
    logic [plet_pkg::SLOT_W-1:0]   oslot;
    logic [plet_pkg::KEY_W-1:0]    okey;
    logic [plet_pkg::COUNT_W-1:0]  ocount;
    logic cfg_we;

    // register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {{(32-plet_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

    plet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plet_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_tvalid && s_tready),
        .in_key    (s_tdata[31:0]),
        .in_slot   (s_tdata[35:32]),
        .cfg_we    (cfg_we),
        .cfg_limit (pwdata[plet_pkg::LIMIT_W-1:0]),
        .limit_q   (limit_q),
        .cmd       (cmd),
        .stat      (stat),
        .out_kind  (m_tuser),
        .out_slot  (oslot),
        .out_key   (okey),
        .out_count (ocount),
        .out_last  (m_tlast)
    );

    // result word packing
    assign m_tdata = {4'd0, ocount, okey, oslot};

endmodule
